FILE: rtl/core/sbndm_pkg.sv
// shared constants, codes and control types of the sbndm string matcher
package sbndm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int ALPHABET    = 256;
    localparam int WORD_BITS   = 32;

    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int PIDX_W  = 5;
    localparam int CFG_W   = 6;
    localparam int POS_W   = 32;

    localparam int ADDR_W  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
    localparam int M_LIM   = (WORD_BITS < MAX_PATTERN) ? WORD_BITS : MAX_PATTERN;

    typedef enum logic [MODE_W-1:0] {
        MODE_PATTERN = 2'd0,
        MODE_TEXT    = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NOP     = 2'd3
    } mode_t;

    typedef struct packed {
        logic accept;
        logic write;
        logic step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic text_scans;
        logic scan_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

FILE: rtl/core/sbndm_in_if.sv
// input channel: mode, data byte and pattern index with valid/ready
interface sbndm_in_if
    import sbndm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic [PIDX_W-1:0] pattern_index;

    modport source (output valid, output mode, output data_byte, output pattern_index,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input pattern_index,
                    output ready);
endinterface

FILE: rtl/core/sbndm_out_if.sv
// result channel: match flag and match start position with valid/ready
interface sbndm_out_if
    import sbndm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             match_found;
    logic [POS_W-1:0] match_start;

    modport source (output valid, output match_found, output match_start, input ready);
    modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

FILE: rtl/core/sbndm_ctrl.sv
// controller state machine sequencing mask writes, window scans and result hand-off
module sbndm_ctrl
    import sbndm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    output logic              in_ready,
    input  ctrl_stat_t        stat,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    case (mode_t'(in_mode))
                        MODE_PATTERN: state_next = ST_WRITE;
                        MODE_TEXT:    state_next = stat.text_scans ? ST_SCAN : ST_IDLE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_pattern_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_mode == MODE_PATTERN) |=> state_reg == ST_WRITE)
        else $error("pattern write did not enter write state");

    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !stat.scan_done) |=> state_reg == ST_SCAN)
        else $error("scan left before completion");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !stat.out_free) |=> state_reg == ST_EMIT)
        else $error("result dropped while output stalled");

endmodule

FILE: rtl/core/sbndm_dp.sv
// datapath: mask table, text window, scan register, position and result register
module sbndm_dp
    import sbndm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [MODE_W-1:0] mode,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [PIDX_W-1:0] pattern_index,
    input  ctrl_cmd_t         cmd,
    output ctrl_stat_t        stat,
    sbndm_out_if.source       result
);

    logic [WORD_BITS-1:0] mask_mem [ALPHABET];
    logic [ALPHABET-1:0]  mask_valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rd_ok_reg;

    logic [BYTE_W-1:0]    window_reg [MAX_PATTERN];
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_inc;
    logic [POS_W-1:0]     text_pos_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [CFG_W-1:0]     pattern_length_reg;
    logic [CFG_W-1:0]     m_eff;
    logic [WORD_BITS-1:0] active;

    logic [ADDR_W-1:0]    wr_addr_reg;
    logic [WORD_BITS-1:0] wr_bit_reg;
    logic                 wr_ok_reg;

    logic [IDX_W-1:0]     j_reg;
    logic [WORD_BITS-1:0] d_reg;
    logic [WORD_BITS-1:0] d_next;
    logic [WORD_BITS-1:0] lookup;

    logic [BYTE_W-1:0]    rd_byte;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_in_alpha;
    logic                 byte_in_alpha;
    logic                 acc_pattern;
    logic                 acc_text;
    logic                 acc_clear;

    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [POS_W-1:0]     out_start_reg;

    assign acc_pattern = cmd.accept && (mode == MODE_PATTERN);
    assign acc_text    = cmd.accept && (mode == MODE_TEXT);
    assign acc_clear   = cmd.accept && (mode == MODE_CLEAR);

    assign m_eff  = (pattern_length_reg > CFG_W'(M_LIM)) ? CFG_W'(M_LIM) : pattern_length_reg;
    assign active = {WORD_BITS{1'b1}} << (7'(WORD_BITS) - 7'(m_eff));

    assign fill_inc = (32'(fill_reg) < MAX_PATTERN) ? fill_reg + FILL_W'(1) : fill_reg;

    assign byte_in_alpha = ({1'b0, data_byte} < 9'(ALPHABET));

    // read address: the new byte on accept, else the next older window byte
    assign rd_byte     = cmd.accept ? data_byte
                                    : window_reg[IDX_W'(MAX_PATTERN - 2) - j_reg];
    assign rd_addr     = rd_byte[ADDR_W-1:0];
    assign rd_in_alpha = ({1'b0, rd_byte} < 9'(ALPHABET));

    assign lookup = rd_ok_reg ? rdata_reg : '0;
    assign d_next = (j_reg == '0) ? (lookup & active) : ((d_reg << 1) & lookup & active);

    assign stat.text_scans = (m_eff != '0) && (32'(fill_inc) >= 32'(m_eff));
    assign stat.scan_done  = (d_next == '0) || (32'(j_reg) == 32'(m_eff) - 32'd1);
    assign stat.out_free   = !out_valid_reg || result.ready;

    assign result.valid       = out_valid_reg;
    assign result.match_found = out_found_reg;
    assign result.match_start = out_start_reg;

    always_ff @(posedge clk)
    begin
        rdata_reg <= mask_mem[rd_addr];
        if (cmd.write && wr_ok_reg)
        begin
            mask_mem[wr_addr_reg] <= lookup | wr_bit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_pattern)
        begin
            wr_addr_reg <= data_byte[ADDR_W-1:0];
            wr_bit_reg  <= WORD_BITS'(1) << (PIDX_W'(WORD_BITS - 1) - pattern_index);
            wr_ok_reg   <= byte_in_alpha;
        end
        if (acc_text)
        begin
            for (int i = 0; i < MAX_PATTERN - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[MAX_PATTERN - 1] <= data_byte;
            pos_reg <= text_pos_reg;
        end
        if (cmd.step)
        begin
            d_reg <= d_next;
        end
        if (cmd.emit)
        begin
            out_found_reg <= (d_reg != '0);
            out_start_reg <= (d_reg != '0) ? pos_reg - (POS_W'(m_eff) - POS_W'(1)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_valid_reg     <= '0;
            rd_ok_reg          <= 1'b0;
            fill_reg           <= '0;
            text_pos_reg       <= '0;
            pattern_length_reg <= CFG_W'(1);
            j_reg              <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= mask_valid_reg[rd_addr] && rd_in_alpha;
            if (cfg_we)
            begin
                pattern_length_reg <= cfg_wdata;
            end
            if (acc_clear)
            begin
                mask_valid_reg <= '0;
                fill_reg       <= '0;
                text_pos_reg   <= '0;
            end
            if (cmd.write && wr_ok_reg)
            begin
                mask_valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (acc_text)
            begin
                fill_reg     <= fill_inc;
                text_pos_reg <= text_pos_reg + POS_W'(1);
                j_reg        <= '0;
            end
            else if (cmd.step)
            begin
                j_reg <= j_reg + IDX_W'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (32'(j_reg) < 32'(m_eff)))
        else $error("scan index beyond pattern length");

    a_no_match_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && d_reg == '0) |=> (!out_found_reg && out_start_reg == '0))
        else $error("mismatch transaction carries a start position");

endmodule

FILE: rtl/core/sbndm_string_matcher.sv
// top level of the sbndm string matcher: controller and datapath
//
// item channel (valid/ready): mode 0 ORs one pattern bit into the mask of
// data_byte, mode 1 feeds one text byte, mode 2 clears masks, window fill and
// text position, mode 3 is ignored. a transaction moves at valid and ready high.
// result channel (valid/ready): one transaction per text byte once the window
// holds pattern_length bytes (max 32), with match_found and the start position.
// pattern_length is written through cfg_we/cfg_wdata while the block is idle;
// the user must keep to this, the block itself does not enforce it.
// a text byte that scans is accepted, then the mask table is read once per
// window byte (up to pattern_length, fewer on early mismatch) through its
// single read port, then the result register is loaded.
// a result waits in the output register while the receiver stalls; pattern and
// clear transactions are still taken, a further text scan holds before hand-off.
// reset clears the mask valid bits, fill count and position at once and sets
// pattern_length to 1; no clearing pass is needed.
module sbndm_string_matcher
    import sbndm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    sbndm_in_if.sink         item,
    sbndm_out_if.source      result
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       in_ready;

    assign item.ready = in_ready;

    sbndm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbndm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mode          (item.mode),
        .data_byte     (item.data_byte),
        .pattern_index (item.pattern_index),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result)
    );

endmodule
